/* sv/rsx_pkg.sv */
// ----------------------------------------------------------------------------
// rsx_pkg
// Widths, stage counts and status codes of the ray/sphere exit coefficient.
// ----------------------------------------------------------------------------
package rsx_pkg;

  localparam int unsigned COORD_WIDTH = 24;
  localparam int unsigned CW          = COORD_WIDTH;
  localparam int unsigned PW          = 2 * CW;        // product of two coordinates
  localparam int unsigned QW          = 4 * CW;        // product of two products
  localparam int unsigned HW          = 2 * CW + 2;    // signed dot product
  localparam int unsigned NW          = 2 * CW + 3;    // signed root numerator
  localparam int unsigned FRAC_SHIFT  = 16;
  localparam int unsigned MW          = NW + FRAC_SHIFT; // scaled dividend, quotient
  localparam int unsigned RW          = PW + 2;        // square root remainder
  localparam int unsigned SQ_STAGES   = PW;            // one root bit per stage
  localparam int unsigned DIV_STAGES  = MW;            // one quotient bit per stage
  localparam int unsigned ALPHA_WIDTH = 32;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROOT  = 2'd1;
  localparam logic [1:0] ST_ZERO_DIR = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

endpackage

/* sv/rsx_if.sv */
// ----------------------------------------------------------------------------
// rsx_if
// Valid/ready channels for the input item and the result item.
// ----------------------------------------------------------------------------
interface rsx_in_if;
  import rsx_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [CW-1:0]   off_x;
  logic signed [CW-1:0]   off_y;
  logic signed [CW-1:0]   off_z;
  logic signed [CW-1:0]   dir_x;
  logic signed [CW-1:0]   dir_y;
  logic signed [CW-1:0]   dir_z;
  logic        [CW-2:0]   radius;
  modport source (output valid, off_x, off_y, off_z, dir_x, dir_y, dir_z, radius,
                  input ready);
  modport sink (input valid, off_x, off_y, off_z, dir_x, dir_y, dir_z, radius,
                output ready);
endinterface

interface rsx_out_if;
  import rsx_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [ALPHA_WIDTH-1:0] alpha;
  logic        [1:0]             status;
  modport source (output valid, alpha, status, input ready);
  modport sink (input valid, alpha, status, output ready);
endinterface

/* sv/ray_sphere_exit_coefficient.sv */
// ----------------------------------------------------------------------------
// ray_sphere_exit_coefficient
// Pipelined solver for the exit point of a ray along w from offset v
// through a sphere of radius r: root of |v + x*w| = r, as Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries v (off_*), w (dir_*) and r (radius), all in Q12.12.
//   res_o carries alpha (Q16.16, saturated) and a status code: ok, no real
//   root, zero direction or saturated.
//   Throughput is one item per cycle while the receiver does not stall.
//   Items pass through the product and sum stages, the square root
//   pipeline that forms the root bit by bit, a numerator register, the
//   divider that forms the quotient bit by bit, and the output register.
//   Reset clears every stage's valid bit; the block takes items as soon
//   as reset is released.
//   All stages advance together. When the receiver stalls with a result
//   waiting, the whole pipeline holds and item_i.ready drops in the same
//   cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ray_sphere_exit_coefficient (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsx_in_if.sink     item_i,
  rsx_out_if.source  res_o
);
  import rsx_pkg::*;

  typedef struct packed {
    logic                 zdir;
    logic                 dneg;
    logic                 pick_low;
    logic signed [HW-1:0] h;
    logic        [PW-1:0] a;
  } sq_side_t;

  typedef struct packed {
    logic          zdir;
    logic          dneg;
    logic          neg;
    logic [PW-1:0] a;
  } dv_side_t;

  logic adv;
  logic res_vld_q;
  logic signed [ALPHA_WIDTH-1:0] res_alpha_q;
  logic [1:0] res_status_q;

  assign adv          = !res_vld_q || res_o.ready;
  assign item_i.ready = adv;
  assign res_o.valid  = res_vld_q;
  assign res_o.alpha  = res_alpha_q;
  assign res_o.status = res_status_q;

  // ---------------- stage 1: coordinate products
  logic signed [CW-1:0] v [3];
  logic signed [CW-1:0] w [3];
  assign v[0] = item_i.off_x;
  assign v[1] = item_i.off_y;
  assign v[2] = item_i.off_z;
  assign w[0] = item_i.dir_x;
  assign w[1] = item_i.dir_y;
  assign w[2] = item_i.dir_z;

  logic                 s1_vld_q;
  logic signed [PW-1:0] s1_ww_q [3];
  logic signed [PW-1:0] s1_vv_q [3];
  logic signed [PW-1:0] s1_wv_q [3];
  logic signed [PW-1:0] s1_crs_q [6];
  logic        [PW-1:0] s1_r2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_ww_q[i] <= w[i] * w[i];
        s1_vv_q[i] <= v[i] * v[i];
        s1_wv_q[i] <= w[i] * v[i];
      end
      s1_crs_q[0] <= w[1] * v[2];
      s1_crs_q[1] <= w[2] * v[1];
      s1_crs_q[2] <= w[2] * v[0];
      s1_crs_q[3] <= w[0] * v[2];
      s1_crs_q[4] <= w[0] * v[1];
      s1_crs_q[5] <= w[1] * v[0];
      s1_r2_q     <= PW'(item_i.radius) * PW'(item_i.radius);
    end
  end

  // ---------------- stage 2: sums and cross product magnitudes
  logic                 s2_vld_q;
  logic        [PW-1:0] s2_a_q;
  logic        [PW-1:0] s2_vsq_q;
  logic signed [HW-1:0] s2_h_q;
  logic        [PW-1:0] s2_cm_q [3];
  logic        [PW-1:0] s2_r2_q;
  logic signed [PW:0]   crs_diff [3];
  logic        [PW:0]   crs_abs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crs_diff[k] = (PW+1)'(s1_crs_q[2*k]) - (PW+1)'(s1_crs_q[2*k+1]);
      crs_abs[k]  = crs_diff[k][PW] ? $unsigned(-crs_diff[k]) : $unsigned(crs_diff[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a_q   <= $unsigned(s1_ww_q[0]) + $unsigned(s1_ww_q[1]) + $unsigned(s1_ww_q[2]);
      s2_vsq_q <= $unsigned(s1_vv_q[0]) + $unsigned(s1_vv_q[1]) + $unsigned(s1_vv_q[2]);
      s2_h_q   <= HW'(s1_wv_q[0]) + HW'(s1_wv_q[1]) + HW'(s1_wv_q[2]);
      for (int k = 0; k < 3; k++) begin
        s2_cm_q[k] <= crs_abs[k][PW-1:0];
      end
      s2_r2_q <= s1_r2_q;
    end
  end

  // ---------------- stage 3: partial products of a*r^2 and the cross squares
  logic                 s3_vld_q;
  logic        [PW-1:0] s3_ar_pp_q [4];
  logic        [PW-1:0] s3_cr_pp_q [3][3];
  logic                 s3_pick_low_q;
  logic                 s3_zdir_q;
  logic signed [HW-1:0] s3_h_q;
  logic        [PW-1:0] s3_a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ar_pp_q[0] <= s2_a_q[CW-1:0]  * s2_r2_q[CW-1:0];
      s3_ar_pp_q[1] <= s2_a_q[CW-1:0]  * s2_r2_q[PW-1:CW];
      s3_ar_pp_q[2] <= s2_a_q[PW-1:CW] * s2_r2_q[CW-1:0];
      s3_ar_pp_q[3] <= s2_a_q[PW-1:CW] * s2_r2_q[PW-1:CW];
      for (int k = 0; k < 3; k++) begin
        s3_cr_pp_q[k][0] <= s2_cm_q[k][CW-1:0]  * s2_cm_q[k][CW-1:0];
        s3_cr_pp_q[k][1] <= s2_cm_q[k][CW-1:0]  * s2_cm_q[k][PW-1:CW];
        s3_cr_pp_q[k][2] <= s2_cm_q[k][PW-1:CW] * s2_cm_q[k][PW-1:CW];
      end
      // smaller root is nonnegative when h <= 0 and |v|^2 >= r^2
      s3_pick_low_q <= (s2_h_q[HW-1] || (s2_h_q == '0)) && (s2_vsq_q >= s2_r2_q);
      s3_zdir_q     <= (s2_a_q == '0);
      s3_h_q        <= s2_h_q;
      s3_a_q        <= s2_a_q;
    end
  end

  // ---------------- stage 4: assemble the wide products
  logic          s4_vld_q;
  logic [QW-1:0] s4_ar2_q;
  logic [QW-1:0] s4_c2_q [3];
  sq_side_t      s4_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_ar2_q <= {s3_ar_pp_q[3], s3_ar_pp_q[0]}
                + ((QW'(s3_ar_pp_q[1]) + QW'(s3_ar_pp_q[2])) << CW);
      for (int k = 0; k < 3; k++) begin
        s4_c2_q[k] <= {s3_cr_pp_q[k][2], s3_cr_pp_q[k][0]}
                    + (QW'(s3_cr_pp_q[k][1]) << (CW + 1));
      end
      s4_side_q <= '{zdir: s3_zdir_q, dneg: 1'b0, pick_low: s3_pick_low_q,
                     h: s3_h_q, a: s3_a_q};
    end
  end

  // ---------------- stage 5: |w x v|^2
  logic          s5_vld_q;
  logic [QW-1:0] s5_ar2_q;
  logic [QW-1:0] s5_cr_q;
  sq_side_t      s5_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_ar2_q  <= s4_ar2_q;
      s5_cr_q   <= s4_c2_q[0] + s4_c2_q[1] + s4_c2_q[2];
      s5_side_q <= s4_side_q;
    end
  end

  // ---------------- stage 6: reduced discriminant, feeds the root pipeline
  logic          sqv_q    [SQ_STAGES+1];
  sq_side_t      sqs_q    [SQ_STAGES+1];
  logic [QW-1:0] sq_rad_q [SQ_STAGES+1];
  logic [RW-1:0] sq_rem_q [SQ_STAGES+1];
  logic [PW-1:0] sq_root_q[SQ_STAGES+1];
  logic [QW:0]   disc;

  assign disc = {1'b0, s5_ar2_q} - {1'b0, s5_cr_q};

  logic [RW+1:0] sq_sh    [SQ_STAGES];
  logic [RW+1:0] sq_trial [SQ_STAGES];
  logic          sq_ge    [SQ_STAGES];

  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      sq_sh[k]    = {sq_rem_q[k], sq_rad_q[k][QW-1 -: 2]};
      sq_trial[k] = (RW+2)'({sq_root_q[k], 2'b01});
      sq_ge[k]    = (sq_sh[k] >= sq_trial[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rad_q[0]  <= disc[QW-1:0];
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sqs_q[0]     <= '{zdir: s5_side_q.zdir, dneg: disc[QW], pick_low: s5_side_q.pick_low,
                        h: s5_side_q.h, a: s5_side_q.a};
      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
        sq_rem_q[k+1]  <= sq_ge[k] ? RW'(sq_sh[k] - sq_trial[k]) : RW'(sq_sh[k]);
        sq_root_q[k+1] <= {sq_root_q[k][PW-2:0], sq_ge[k]};
        sqs_q[k+1]     <= sqs_q[k];
      end
    end
  end

  // ---------------- numerator: -h - s for the smaller root, -h + s otherwise
  logic signed [NW-1:0] num_neg_h;
  logic signed [NW-1:0] num_s;
  logic signed [NW-1:0] num;
  logic        [NW-1:0] num_mag;

  assign num_neg_h = -NW'(sqs_q[SQ_STAGES].h);
  assign num_s     = $signed({{(NW-PW){1'b0}}, sq_root_q[SQ_STAGES]});
  assign num       = sqs_q[SQ_STAGES].pick_low ? (num_neg_h - num_s) : (num_neg_h + num_s);
  assign num_mag   = num[NW-1] ? $unsigned(-num) : $unsigned(num);

  // ---------------- restoring divider, one quotient bit per stage
  logic          dvv_q   [DIV_STAGES+1];
  dv_side_t      dvs_q   [DIV_STAGES+1];
  logic [MW-1:0] dv_n_q  [DIV_STAGES+1];
  logic [PW-1:0] dv_rem_q[DIV_STAGES+1];

  logic [PW:0] dv_sh [DIV_STAGES];
  logic        dv_ge [DIV_STAGES];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_sh[k] = {dv_rem_q[k], dv_n_q[k][MW-1]};
      dv_ge[k] = (dv_sh[k] >= {1'b0, dvs_q[k].a});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_n_q[0]   <= {num_mag, {FRAC_SHIFT{1'b0}}};
      dv_rem_q[0] <= '0;
      dvs_q[0]    <= '{zdir: sqs_q[SQ_STAGES].zdir, dneg: sqs_q[SQ_STAGES].dneg,
                       neg: num[NW-1], a: sqs_q[SQ_STAGES].a};
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_rem_q[k+1] <= dv_ge[k] ? PW'(dv_sh[k] - {1'b0, dvs_q[k].a}) : PW'(dv_sh[k]);
        dv_n_q[k+1]   <= {dv_n_q[k][MW-2:0], dv_ge[k]};
        dvs_q[k+1]    <= dvs_q[k];
      end
    end
  end

  // ---------------- result: floor rounding, saturation, status
  logic [MW-1:0]           q;
  logic [MW:0]             q_up;
  logic                    rem_nz;
  logic signed [ALPHA_WIDTH-1:0] alpha_d;
  logic [1:0]              status_d;
  dv_side_t                fin;

  assign q      = dv_n_q[DIV_STAGES];
  assign fin    = dvs_q[DIV_STAGES];
  assign rem_nz = (dv_rem_q[DIV_STAGES] != '0);
  assign q_up   = (MW+1)'(q) + (MW+1)'(rem_nz);

  always_comb begin
    alpha_d  = '0;
    status_d = ST_OK;
    if (fin.zdir) begin
      status_d = ST_ZERO_DIR;
    end else if (fin.dneg) begin
      status_d = ST_NO_ROOT;
    end else if (!fin.neg) begin
      if (q[MW-1:ALPHA_WIDTH-1] != '0) begin
        alpha_d  = {1'b0, {(ALPHA_WIDTH-1){1'b1}}};
        status_d = ST_SAT;
      end else begin
        alpha_d = $signed(q[ALPHA_WIDTH-1:0]);
      end
    end else begin
      if (q_up > (MW+1)'({1'b1, {(ALPHA_WIDTH-1){1'b0}}})) begin
        alpha_d  = {1'b1, {(ALPHA_WIDTH-1){1'b0}}};
        status_d = ST_SAT;
      end else begin
        alpha_d = $signed(-q_up[ALPHA_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_alpha_q  <= alpha_d;
      res_status_q <= status_d;
    end
  end

  // valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      for (int k = 0; k <= SQ_STAGES; k++) begin
        sqv_q[k] <= 1'b0;
      end
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dvv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      s1_vld_q <= item_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      sqv_q[0] <= s5_vld_q;
      for (int k = 0; k < SQ_STAGES; k++) begin
        sqv_q[k+1] <= sqv_q[k];
      end
      dvv_q[0] <= sqv_q[SQ_STAGES];
      for (int k = 0; k < DIV_STAGES; k++) begin
        dvv_q[k+1] <= dvv_q[k];
      end
      res_vld_q <= dvv_q[DIV_STAGES];
    end
  end

endmodule

/* sv/rsx_checker.sv */
// ----------------------------------------------------------------------------
// rsx_checker
// Port-level checks on the ray/sphere exit coefficient block.
// ----------------------------------------------------------------------------
module rsx_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic signed [rsx_pkg::ALPHA_WIDTH-1:0] alpha_i,
  input logic        [1:0]                      status_i
);
  import rsx_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(alpha_i) && $stable(status_i))
    else $error("result changed while stalled");

  // input side only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without an output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_SAT |->
      alpha_i == 32'sh7fff_ffff || alpha_i == 32'sh8000_0000)
    else $error("saturated status with unsaturated alpha");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_NO_ROOT || status_i == ST_ZERO_DIR) |-> alpha_i == '0)
    else $error("error status with nonzero alpha");

endmodule

bind ray_sphere_exit_coefficient rsx_checker u_rsx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .alpha_i     (res_o.alpha),
  .status_i    (res_o.status)
);
